@@ sv/argm_pkg.sv @@
// Shared types and constants for the audio ring FIFO with gain mixing.
package argm_pkg;

  localparam int STORAGE_FRAMES = 1024;
  localparam int CHANNELS       = 2;
  localparam int SAMPLE_BITS    = 16;

  localparam int ADDR_W    = $clog2(STORAGE_FRAMES);
  localparam int PTR_W     = ADDR_W + 1;
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 14;
  localparam int MASK_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_STARVED = 2'd1,
    ST_DROPPED = 2'd2
  } status_e;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_READ  = 1'b1
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PLAYBACK = 2'd0,
    CFG_CAPACITY = 2'd1,
    CFG_GAIN_L   = 2'd2,
    CFG_GAIN_R   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic                          req_type;
    logic signed [SAMPLE_BITS-1:0] sample_left;
    logic signed [SAMPLE_BITS-1:0] sample_right;
    logic [MASK_W-1:0]             channel_mask;
    logic signed [SAMPLE_BITS-1:0] dest_left;
    logic signed [SAMPLE_BITS-1:0] dest_right;
  } in_item_t;

  typedef struct packed {
    status_e                       status;
    logic signed [SAMPLE_BITS-1:0] mix_left;
    logic signed [SAMPLE_BITS-1:0] mix_right;
    logic [PTR_W-1:0]              fill_level;
  } out_item_t;

  typedef struct packed {
    logic                     playback_enable;
    logic [PTR_W-1:0]         cap_limit;
    logic signed [GAIN_W-1:0] gain_left;
    logic signed [GAIN_W-1:0] gain_right;
  } cfg_t;

  typedef struct packed {
    status_e                       status;
    logic                          do_mix;
    logic signed [SAMPLE_BITS-1:0] sample_left;
    logic signed [SAMPLE_BITS-1:0] sample_right;
    logic signed [SAMPLE_BITS-1:0] dest_left;
    logic signed [SAMPLE_BITS-1:0] dest_right;
    logic [PTR_W-1:0]              fill_level;
  } cmd_t;

endpackage

@@ sv/argm_front.sv @@
// Front end: pointer bookkeeping, item classification and the sample memory.
module argm_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  argm_pkg::cfg_t     cfg_i,
  input  logic               accept_i,
  input  argm_pkg::in_item_t item_i,
  input  logic               cmd_ready_i,
  output logic               cmd_valid_o,
  output argm_pkg::cmd_t     cmd_o,
  output logic               busy_o
);
  import argm_pkg::*;

  logic signed [SAMPLE_BITS-1:0] mem_l [STORAGE_FRAMES];
  logic signed [SAMPLE_BITS-1:0] mem_r [STORAGE_FRAMES];

  logic [PTR_W-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [PTR_W-1:0] cap_sat, fill, fill_next;
  logic             is_read, do_write, do_read;
  logic             v_q, v_d;
  cmd_t             c_q, c_d;
  logic signed [SAMPLE_BITS-1:0] rd_l_q, rd_r_q, wr_l, wr_r;

  assign cap_sat = (cfg_i.cap_limit > PTR_W'(STORAGE_FRAMES)) ?
                   PTR_W'(STORAGE_FRAMES) : cfg_i.cap_limit;
  assign fill      = wp_q - rp_q;
  assign is_read   = (item_i.req_type == REQ_READ);
  assign do_write  = !is_read && (fill < cap_sat);
  assign do_read   = is_read && cfg_i.playback_enable && (fill != '0);
  assign fill_next = fill + PTR_W'(do_write) - PTR_W'(do_read);
  assign wr_l = item_i.channel_mask[0] ? item_i.sample_left : '0;
  assign wr_r = ((CHANNELS > 1) && item_i.channel_mask[1]) ? item_i.sample_right : '0;

  always_comb begin
    wp_d = wp_q;
    rp_d = rp_q;
    v_d  = v_q && !cmd_ready_i;
    c_d  = c_q;
    if (accept_i) begin
      wp_d = wp_q + PTR_W'(do_write);
      rp_d = rp_q + PTR_W'(do_read);
      v_d  = 1'b1;
      c_d.do_mix       = do_read;
      c_d.sample_left  = '0;
      c_d.sample_right = '0;
      c_d.fill_level   = fill_next;
      if (is_read) begin
        c_d.status     = do_read ? ST_OK : ST_STARVED;
        c_d.dest_left  = item_i.dest_left;
        c_d.dest_right = item_i.dest_right;
      end else begin
        c_d.status     = do_write ? ST_OK : ST_DROPPED;
        c_d.dest_left  = '0;
        c_d.dest_right = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      v_q  <= 1'b0;
    end else begin
      wp_q <= wp_d;
      rp_q <= rp_d;
      v_q  <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d;
    if (accept_i && do_write) begin
      mem_l[wp_q[ADDR_W-1:0]] <= wr_l;
      mem_r[wp_q[ADDR_W-1:0]] <= wr_r;
    end
    if (accept_i && do_read) begin
      rd_l_q <= mem_l[rp_q[ADDR_W-1:0]];
      rd_r_q <= mem_r[rp_q[ADDR_W-1:0]];
    end
  end

  always_comb begin
    cmd_o = c_q;
    if (c_q.do_mix) begin
      cmd_o.sample_left  = rd_l_q;
      cmd_o.sample_right = rd_r_q;
    end
  end

  assign cmd_valid_o = v_q;
  assign busy_o      = v_q && !cmd_ready_i;

endmodule

@@ sv/argm_cmd_queue.sv @@
// Two-entry command queue between the front end and the mixer.
module argm_cmd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  argm_pkg::cmd_t data_i,
  output logic           ready_o,
  output logic           valid_o,
  input  logic           pop_i,
  output argm_pkg::cmd_t data_o
);
  import argm_pkg::*;

  cmd_t       ent_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = ent_q[rd_q];

  always_comb begin
    wr_d  = wr_q ^ do_push;
    rd_d  = rd_q ^ do_pop;
    cnt_d = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_q] <= data_i;
    end
  end

endmodule

@@ sv/argm_back.sv @@
// Back end: gain multiply, rounding, saturated mix and the result queue.
module argm_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  argm_pkg::cfg_t      cfg_i,
  input  logic                cmd_valid_i,
  input  argm_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  output logic                empty,
  input  logic                pop,
  output argm_pkg::out_item_t out_item_o
);
  import argm_pkg::*;

  localparam int PROD_W = SAMPLE_BITS + GAIN_W;
  localparam int MIX_W  = PROD_W + 2;
  localparam logic signed [MIX_W-1:0] SAT_MAX = MIX_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [MIX_W-1:0] SAT_MIN = -MIX_W'(64'sd1 <<< (SAMPLE_BITS - 1));
  localparam logic signed [MIX_W-1:0] RND     = MIX_W'(64'sd1 <<< (GAIN_FRAC - 1));

  typedef struct packed {
    status_e                       status;
    logic                          do_mix;
    logic signed [PROD_W-1:0]      prod_l;
    logic signed [PROD_W-1:0]      prod_r;
    logic signed [SAMPLE_BITS-1:0] dest_l;
    logic signed [SAMPLE_BITS-1:0] dest_r;
    logic [PTR_W-1:0]              fill_level;
  } mul_t;

  function automatic logic signed [SAMPLE_BITS-1:0] sat_mix(
    input logic signed [PROD_W-1:0]      prod,
    input logic signed [SAMPLE_BITS-1:0] dest
  );
    logic signed [MIX_W-1:0] scaled;
    logic signed [MIX_W-1:0] sum;
    scaled = (MIX_W'(prod) + RND) >>> GAIN_FRAC;
    sum    = scaled + MIX_W'(dest);
    if (sum > SAT_MAX) begin
      sum = SAT_MAX;
    end else if (sum < SAT_MIN) begin
      sum = SAT_MIN;
    end
    return sum[SAMPLE_BITS-1:0];
  endfunction

  logic       m_v_q, m_v_d, m_adv, m_load;
  mul_t       m_q, m_d;
  out_item_t  res;
  out_item_t  ent_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_pop;

  assign do_pop    = pop && !empty;
  assign m_adv     = m_v_q && ((cnt_q != 2'd2) || do_pop);
  assign m_load    = cmd_valid_i && (!m_v_q || m_adv);
  assign cmd_pop_o = m_load;

  always_comb begin
    m_d            = m_q;
    m_d.status     = cmd_i.status;
    m_d.do_mix     = cmd_i.do_mix;
    m_d.prod_l     = PROD_W'(cmd_i.sample_left) * PROD_W'(cfg_i.gain_left);
    m_d.prod_r     = PROD_W'(cmd_i.sample_right) * PROD_W'(cfg_i.gain_right);
    m_d.dest_l     = cmd_i.dest_left;
    m_d.dest_r     = cmd_i.dest_right;
    m_d.fill_level = cmd_i.fill_level;
    m_v_d          = m_load || (m_v_q && !m_adv);
  end

  always_comb begin
    res.status     = m_q.status;
    res.fill_level = m_q.fill_level;
    res.mix_left   = m_q.do_mix ? sat_mix(m_q.prod_l, m_q.dest_l) : m_q.dest_l;
    res.mix_right  = m_q.do_mix ? sat_mix(m_q.prod_r, m_q.dest_r) : m_q.dest_r;
  end

  always_comb begin
    wr_d  = wr_q ^ m_adv;
    rd_d  = rd_q ^ do_pop;
    cnt_d = cnt_q + 2'(m_adv) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      m_v_q <= m_v_d;
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_load) begin
      m_q <= m_d;
    end
    if (m_adv) begin
      ent_q[wr_q] <= res;
    end
  end

  assign empty      = (cnt_q == 2'd0);
  assign out_item_o = ent_q[rd_q];

endmodule

@@ sv/audio_ring_fifo_gain_mix.sv @@
// Top level of the two-channel audio ring FIFO with gain mixing on read.
//
//   channel   handshake            payload            accepted when
//   input     push / full          in_item_i          push && !full
//   result    empty / pop          out_item_o         pop && !empty
//   config    cfg_valid_i / _ready cfg_index_i, data  cfg_valid_i && cfg_ready_o
//
// One item per cycle sustained while full stays low; a result passes through the
// front register and memory read, the command queue, the multiplier and the
// result queue before it shows on the ports.
// Reset clears the pointers and queues; the sample memory is not cleared.
// A stalled result queue backs up through the command queue into full.
// Configuration is always ready.
module audio_ring_fifo_gain_mix (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  argm_pkg::in_item_t         in_item_i,
  output logic                       empty,
  input  logic                       pop,
  output argm_pkg::out_item_t        out_item_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [argm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [argm_pkg::CFG_DAT_W-1:0] cfg_data_i
);
  import argm_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic accept, busy;
  logic f_valid, q_ready, q_valid, q_pop;
  cmd_t f_cmd, q_cmd;

  assign cfg_ready_o = 1'b1;
  assign full        = busy;
  assign accept      = push && !full;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_PLAYBACK: cfg_d.playback_enable = cfg_data_i[0];
        CFG_CAPACITY: cfg_d.cap_limit       = cfg_data_i[PTR_W-1:0];
        CFG_GAIN_L:   cfg_d.gain_left       = cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_R:   cfg_d.gain_right      = cfg_data_i[GAIN_W-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.playback_enable <= 1'b1;
      cfg_q.cap_limit       <= PTR_W'(STORAGE_FRAMES);
      cfg_q.gain_left       <= GAIN_W'(16384);
      cfg_q.gain_right      <= GAIN_W'(16384);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  argm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .accept_i    (accept),
    .item_i      (in_item_i),
    .cmd_ready_i (q_ready),
    .cmd_valid_o (f_valid),
    .cmd_o       (f_cmd),
    .busy_o      (busy)
  );

  argm_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .data_i  (f_cmd),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_cmd)
  );

  argm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o)
  );

endmodule

@@ sv/argm_checker.sv @@
// Port-level checker for the audio ring FIFO, bound to the top level.
module argm_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       push,
  input logic                       full,
  input argm_pkg::in_item_t         in_item_i,
  input logic                       empty,
  input logic                       pop,
  input argm_pkg::out_item_t        out_item_o,
  input logic                       cfg_valid_i,
  input logic                       cfg_ready_o,
  input logic [argm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input logic [argm_pkg::CFG_DAT_W-1:0] cfg_data_i
);
  import argm_pkg::*;

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result queue not empty after reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("waiting result changed");

  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.status == ST_DROPPED) |->
      (out_item_o.mix_left == '0 && out_item_o.mix_right == '0))
    else $error("dropped write carries nonzero mix");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_item_o.fill_level <= PTR_W'(STORAGE_FRAMES)))
    else $error("fill level above storage");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_item_o.status == ST_OK || out_item_o.status == ST_STARVED ||
                out_item_o.status == ST_DROPPED))
    else $error("illegal status code");

endmodule

bind audio_ring_fifo_gain_mix argm_checker u_argm_checker (.*);
